### hw/rtl/rgb_to_hsv_converter_core_macros.svh
// Assertion macros shared by the RGB to HSV converter modules.
`ifndef RGB_TO_HSV_CONVERTER_CORE_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define RGB2HSV_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define RGB2HSV_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/rgb2hsv_pkg.sv
// Types and constants shared by the RGB to HSV converter modules.
package rgb2hsv_pkg;

  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned DIFF_W      = CHAN_W + 1;
  localparam int unsigned REM_W       = 11;
  localparam int unsigned QUO_W       = 16;
  localparam int unsigned STEPS_STAGE = 4;
  localparam int unsigned DIV_STAGES  = QUO_W / STEPS_STAGE;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_e;

  typedef struct packed {
    logic [CHAN_W-1:0]        hi;
    logic [CHAN_W-1:0]        lo;
    sector_e                  sector;
    logic [DIFF_W-1:0]        diff;   // two's complement channel difference
  } sort_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [REM_W-1:0] divisor;
    logic [QUO_W-1:0] num;            // dividend bits still to shift in, msb first
    logic [QUO_W-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    div_lane_t         hue;
    div_lane_t         sat;
    logic [CHAN_W-1:0] value;
  } div_pipe_t;

endpackage

### hw/rtl/rgb2hsv_sort.sv
// First stage: find max, min, the winning sector and its channel difference.
module rgb2hsv_sort (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [rgb2hsv_pkg::CHAN_W-1:0]  red_i,
  input  logic [rgb2hsv_pkg::CHAN_W-1:0]  green_i,
  input  logic [rgb2hsv_pkg::CHAN_W-1:0]  blue_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output rgb2hsv_pkg::sort_t              out_data_o
);

  logic               valid_q;
  rgb2hsv_pkg::sort_t data_d, data_q;
  logic [rgb2hsv_pkg::CHAN_W-1:0] rg_max, rg_min;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_comb begin
    rg_max    = (red_i >= green_i) ? red_i : green_i;
    rg_min    = (red_i <= green_i) ? red_i : green_i;
    data_d.hi = (rg_max >= blue_i) ? rg_max : blue_i;
    data_d.lo = (rg_min <= blue_i) ? rg_min : blue_i;
    // Ties: red beats green, green beats blue.
    if (red_i == data_d.hi) begin
      data_d.sector = rgb2hsv_pkg::SEC_RED;
      data_d.diff   = {1'b0, green_i} - {1'b0, blue_i};
    end else if (green_i == data_d.hi) begin
      data_d.sector = rgb2hsv_pkg::SEC_GREEN;
      data_d.diff   = {1'b0, blue_i} - {1'b0, red_i};
    end else begin
      data_d.sector = rgb2hsv_pkg::SEC_BLUE;
      data_d.diff   = {1'b0, red_i} - {1'b0, green_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

### hw/rtl/rgb2hsv_prep.sv
// Second stage: form delta, the wrapped hue numerator and both divider lanes.
module rgb2hsv_prep (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  rgb2hsv_pkg::sort_t     in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output rgb2hsv_pkg::div_pipe_t out_data_o
);

  localparam int unsigned NumW = rgb2hsv_pkg::CHAN_W + rgb2hsv_pkg::QUO_W;

  logic                   valid_q;
  rgb2hsv_pkg::div_pipe_t data_d, data_q;
  logic [rgb2hsv_pkg::CHAN_W-1:0] delta;
  logic [rgb2hsv_pkg::REM_W-1:0]  off_d, delta6;
  logic [rgb2hsv_pkg::REM_W:0]    s_raw, s_adj;
  logic [NumW-1:0]                sat_num;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_comb begin
    delta  = in_data_i.hi - in_data_i.lo;
    delta6 = {1'b0, delta, 2'b00} + {2'b00, delta, 1'b0};
    unique case (in_data_i.sector)
      rgb2hsv_pkg::SEC_RED:   off_d = '0;
      rgb2hsv_pkg::SEC_GREEN: off_d = {2'b00, delta, 1'b0};
      rgb2hsv_pkg::SEC_BLUE:  off_d = {1'b0, delta, 2'b00};
      default:                off_d = '0;
    endcase
    s_raw = {1'b0, off_d}
          + {{(rgb2hsv_pkg::REM_W + 1 - rgb2hsv_pkg::DIFF_W){in_data_i.diff[rgb2hsv_pkg::DIFF_W-1]}},
             in_data_i.diff};
    // Wrap a negative sector position back into one full turn.
    s_adj = s_raw[rgb2hsv_pkg::REM_W] ? (s_raw + {1'b0, delta6}) : s_raw;

    // delta*65535 = delta*65536 - delta; its top byte is below max.
    sat_num = {delta, {rgb2hsv_pkg::QUO_W{1'b0}}} - {{rgb2hsv_pkg::QUO_W{1'b0}}, delta};

    // A zero divisor becomes one: the numerator is then zero too, and so is the quotient.
    data_d.hue.rem     = s_adj[rgb2hsv_pkg::REM_W-1:0];
    data_d.hue.divisor = (delta == '0) ? rgb2hsv_pkg::REM_W'(1) : delta6;
    data_d.hue.num     = '0;
    data_d.hue.quo     = '0;

    data_d.sat.rem     = rgb2hsv_pkg::REM_W'(sat_num[NumW-1:rgb2hsv_pkg::QUO_W]);
    data_d.sat.divisor = (in_data_i.hi == '0) ? rgb2hsv_pkg::REM_W'(1)
                                               : rgb2hsv_pkg::REM_W'(in_data_i.hi);
    data_d.sat.num     = sat_num[rgb2hsv_pkg::QUO_W-1:0];
    data_d.sat.quo     = '0;

    data_d.value       = in_data_i.hi;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

### hw/rtl/rgb2hsv_div_stage.sv
// One restoring-divider stage: a few quotient bits for both hue and saturation.
`include "rgb_to_hsv_converter_core_macros.svh"

module rgb2hsv_div_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  rgb2hsv_pkg::div_pipe_t in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output rgb2hsv_pkg::div_pipe_t out_data_o
);

  function automatic rgb2hsv_pkg::div_lane_t step_lane(input rgb2hsv_pkg::div_lane_t l);
    rgb2hsv_pkg::div_lane_t         res;
    logic [rgb2hsv_pkg::REM_W:0]    trial;
    res = l;
    for (int unsigned i = 0; i < rgb2hsv_pkg::STEPS_STAGE; i++) begin
      trial   = {res.rem, res.num[rgb2hsv_pkg::QUO_W-1]};
      res.num = {res.num[rgb2hsv_pkg::QUO_W-2:0], 1'b0};
      if (trial >= {1'b0, res.divisor}) begin
        res.rem = rgb2hsv_pkg::REM_W'(trial - {1'b0, res.divisor});
        res.quo = {res.quo[rgb2hsv_pkg::QUO_W-2:0], 1'b1};
      end else begin
        res.rem = trial[rgb2hsv_pkg::REM_W-1:0];
        res.quo = {res.quo[rgb2hsv_pkg::QUO_W-2:0], 1'b0};
      end
    end
    return res;
  endfunction

  logic                   valid_q;
  rgb2hsv_pkg::div_pipe_t data_d, data_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_comb begin
    data_d.hue   = step_lane(in_data_i.hue);
    data_d.sat   = step_lane(in_data_i.sat);
    data_d.value = in_data_i.value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  // Partial remainders must stay below their divisors or the quotient is wrong.
  `RGB2HSV_ASSERT_IMP(a_hue_rem_bound, clk_i, rst_ni, valid_q, data_q.hue.rem < data_q.hue.divisor, "hue remainder not below divisor")
  `RGB2HSV_ASSERT_IMP(a_sat_rem_bound, clk_i, rst_ni, valid_q, data_q.sat.rem < data_q.sat.divisor, "saturation remainder not below divisor")
  // Hold a stalled beat in the stage.
  `RGB2HSV_ASSERT_NXT(a_stage_holds, clk_i, rst_ni, valid_q && !out_ready_i, valid_q, "beat lost while stalled")

endmodule

### hw/rtl/rgb_to_hsv_converter_core.sv
// Top level of the pipelined RGB to HSV converter.
//
// Usage:
//   Input channel: red_in_i, green_in_i, blue_in_i with in_valid_i / in_ready_o.
//   Output channel: hue_out_o, saturation_out_o, value_out_o with
//   out_valid_o / out_ready_i. A beat moves when valid and ready are both high.
//   One input beat gives exactly one output beat, in order.
//   Pipeline: six register stages, sort, prep, then four divider stages
//   of four quotient bits each. Throughput: one pixel per clock while
//   out_ready_i is high; the two 16-bit divisions are spread over the
//   four divider stages, each stage retiring four bits.
//   Every stage has its own valid bit and takes a new beat whenever it is
//   empty or its contents move on, so bubbles close up under back-pressure.
//   Stall: while out_ready_i is low the last stage holds its beat steady;
//   earlier stages keep filling until full, then in_ready_o drops.
//   Reset (rst_ni low, asynchronous) empties every stage; no clearing pass.
`include "rgb_to_hsv_converter_core_macros.svh"

module rgb_to_hsv_converter_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [rgb2hsv_pkg::CHAN_W-1:0]       red_in_i,
  input  logic [rgb2hsv_pkg::CHAN_W-1:0]       green_in_i,
  input  logic [rgb2hsv_pkg::CHAN_W-1:0]       blue_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [rgb2hsv_pkg::QUO_W-1:0]        hue_out_o,
  output logic [rgb2hsv_pkg::QUO_W-1:0]        saturation_out_o,
  output logic [rgb2hsv_pkg::CHAN_W-1:0]       value_out_o
);

  localparam int unsigned NStg = rgb2hsv_pkg::DIV_STAGES;

  // Sort stage to prep stage.
  logic               sort_valid, sort_ready;
  rgb2hsv_pkg::sort_t sort_data;

  // Divider chain: index 0 is the prep stage output, index NStg the last stage.
  logic [NStg:0]          dv_valid;
  logic [NStg:0]          dv_ready;
  rgb2hsv_pkg::div_pipe_t dv_data [NStg+1];

  // Find max, min and the sector.
  rgb2hsv_sort u_sort (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .red_i       (red_in_i),
    .green_i     (green_in_i),
    .blue_i      (blue_in_i),
    .out_valid_o (sort_valid),
    .out_ready_i (sort_ready),
    .out_data_o  (sort_data)
  );

  // Build the hue and saturation numerators and divisors.
  rgb2hsv_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sort_valid),
    .in_ready_o  (sort_ready),
    .in_data_i   (sort_data),
    .out_valid_o (dv_valid[0]),
    .out_ready_i (dv_ready[0]),
    .out_data_o  (dv_data[0])
  );

  // Advance both divisions a few quotient bits per stage.
  for (genvar gi = 0; gi < NStg; gi++) begin : g_div
    rgb2hsv_div_stage u_div_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (dv_valid[gi]),
      .in_ready_o  (dv_ready[gi]),
      .in_data_i   (dv_data[gi]),
      .out_valid_o (dv_valid[gi+1]),
      .out_ready_i (dv_ready[gi+1]),
      .out_data_o  (dv_data[gi+1])
    );
  end

  // The last divider stage doubles as the output register.
  assign dv_ready[NStg]   = out_ready_i;
  assign out_valid_o      = dv_valid[NStg];
  assign hue_out_o        = dv_data[NStg].hue.quo;
  assign saturation_out_o = dv_data[NStg].sat.quo;
  assign value_out_o      = dv_data[NStg].value;

  // A black pixel has neither hue nor saturation.
  `RGB2HSV_ASSERT_IMP(a_black_no_colour, clk_i, rst_ni, out_valid_o && value_out_o == '0, saturation_out_o == '0 && hue_out_o == '0, "black pixel with nonzero hue or saturation")
  // Zero saturation only arises for grey, whose hue is zero.
  `RGB2HSV_ASSERT_IMP(a_grey_no_hue, clk_i, rst_ni, out_valid_o && saturation_out_o == '0, hue_out_o == '0, "grey pixel with nonzero hue")
  // A stalled output beat stays in place, so the input side cannot be ready while full.
  `RGB2HSV_ASSERT_NXT(a_stall_holds_valid, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "output beat dropped while stalled")

endmodule

### bench/tb_top.sv
// Self-checking bench for the pipelined RGB to HSV converter core.
module tb_top;

  // Give up once this many cycles pass with no beat moving on either side.
  localparam int unsigned IDLE_LIMIT  = 2000;
  // Drain time after the last expected beat: pipeline depth plus margin.
  localparam int unsigned TAIL_CYCLES = 12;
  localparam int unsigned N_RANDOM    = 1026;
  localparam int unsigned N_DIRECTED  = 24;

  // Hand-picked pixels: black, white and greys, the primaries and secondaries,
  // ties for the maximum, hue wrap-round in the red sector, and tiny deltas.
  localparam logic [23:0] DIRECTED_PIXELS [N_DIRECTED] = '{
    24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101,
    24'hFF0000, 24'h00FF00, 24'h0000FF,
    24'hFFFF00, 24'h00FFFF, 24'hFF00FF,
    24'hFF0001, 24'hFF0100, 24'h01FF00, 24'h00FF01,
    24'h0100FF, 24'h0001FF, 24'h010000, 24'h000001,
    24'hFEFF00, 24'hFF00FE, 24'h7F807F, 24'h000100,
    24'hFFFEFE, 24'h01FFFF
  };

  typedef struct packed {
    logic [rgb2hsv_pkg::QUO_W-1:0]  hue;
    logic [rgb2hsv_pkg::QUO_W-1:0]  sat;
    logic [rgb2hsv_pkg::CHAN_W-1:0] value;
  } hsv_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_PERIODIC,
    RX_RANDOM,
    RX_BURSTY
  } rx_mode_e;

  // Hold the expected HSV beats in arrival order and tally what was covered.
  class hsv_scoreboard;
    hsv_t        expected_q[$];
    int unsigned pixels_in;
    int unsigned beats_checked;
    int unsigned mismatches;
    int unsigned n_black;
    int unsigned n_gray;
    int unsigned n_wrap;
    int unsigned n_sector[3];

    // Work out the HSV triple of one pixel in exact integer arithmetic.
    function hsv_t convert(logic [rgb2hsv_pkg::CHAN_W-1:0] r,
                           logic [rgb2hsv_pkg::CHAN_W-1:0] g,
                           logic [rgb2hsv_pkg::CHAN_W-1:0] b);
      hsv_t                 res;
      rgb2hsv_pkg::sector_e sector;
      int                   hi;
      int                   lo;
      int                   delta;
      int                   pos;
      int unsigned          hue_full;
      hi    = (r > g) ? r : g;
      hi    = (hi > b) ? hi : b;
      lo    = (r < g) ? r : g;
      lo    = (lo < b) ? lo : b;
      delta = hi - lo;
      res.value = rgb2hsv_pkg::CHAN_W'(hi);
      res.sat   = (hi == 0) ? '0 : rgb2hsv_pkg::QUO_W'((delta * 65535) / hi);
      res.hue   = '0;
      if (hi == 0) n_black++;
      if (delta == 0) begin
        n_gray++;
      end else begin
        // Red wins ties over green, and green over blue.
        if (r == hi)      sector = rgb2hsv_pkg::SEC_RED;
        else if (g == hi) sector = rgb2hsv_pkg::SEC_GREEN;
        else              sector = rgb2hsv_pkg::SEC_BLUE;
        n_sector[sector]++;
        case (sector)
          rgb2hsv_pkg::SEC_RED:   pos = int'(g) - int'(b);
          rgb2hsv_pkg::SEC_GREEN: pos = 2 * delta + int'(b) - int'(r);
          default:                pos = 4 * delta + int'(r) - int'(g);
        endcase
        if (pos < 0) begin
          pos += 6 * delta;
          n_wrap++;
        end
        hue_full = (int'(pos) * 65536) / (6 * delta);
        res.hue  = rgb2hsv_pkg::QUO_W'(hue_full);
      end
      return res;
    endfunction

    function void note_pixel(logic [rgb2hsv_pkg::CHAN_W-1:0] r,
                             logic [rgb2hsv_pkg::CHAN_W-1:0] g,
                             logic [rgb2hsv_pkg::CHAN_W-1:0] b);
      expected_q.push_back(convert(r, g, b));
      pixels_in++;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_beat(hsv_t got);
      hsv_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected beat hue=%h sat=%h value=%h",
                         got.hue, got.sat, got.value));
      end else begin
        want = expected_q.pop_front();
        beats_checked++;
        if (got.hue !== want.hue)
          report($sformatf("beat %0d hue %h, want %h", beats_checked, got.hue, want.hue));
        if (got.sat !== want.sat)
          report($sformatf("beat %0d saturation %h, want %h",
                           beats_checked, got.sat, want.sat));
        if (got.value !== want.value)
          report($sformatf("beat %0d value %h, want %h",
                           beats_checked, got.value, want.value));
      end
    endtask
  endclass

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_ready_o;
  logic [rgb2hsv_pkg::CHAN_W-1:0] red_in_i    = '0;
  logic [rgb2hsv_pkg::CHAN_W-1:0] green_in_i  = '0;
  logic [rgb2hsv_pkg::CHAN_W-1:0] blue_in_i   = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  logic [rgb2hsv_pkg::QUO_W-1:0]  hue_out_o;
  logic [rgb2hsv_pkg::QUO_W-1:0]  saturation_out_o;
  logic [rgb2hsv_pkg::CHAN_W-1:0] value_out_o;

  hsv_scoreboard sb = new();

  rgb_to_hsv_converter_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .red_in_i         (red_in_i),
    .green_in_i       (green_in_i),
    .blue_in_i        (blue_in_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .hue_out_o        (hue_out_o),
    .saturation_out_o (saturation_out_o),
    .value_out_o      (value_out_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Present one pixel and hold it until the core takes the beat.
  task automatic send_pixel(input logic [rgb2hsv_pkg::CHAN_W-1:0] r,
                            input logic [rgb2hsv_pkg::CHAN_W-1:0] g,
                            input logic [rgb2hsv_pkg::CHAN_W-1:0] b);
    in_valid_i <= 1'b1;
    red_in_i   <= r;
    green_in_i <= g;
    blue_in_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_pixel(r, g, b);
  endtask

  function automatic logic [rgb2hsv_pkg::CHAN_W-1:0] extreme_chan();
    return $urandom_range(0, 1) ? rgb2hsv_pkg::CHAN_W'($urandom_range(0, 1))
                                : rgb2hsv_pkg::CHAN_W'(254 + $urandom_range(0, 1));
  endfunction

  // Draw a random pixel: mostly uniform, with a share of near-greys, ties for
  // the maximum and channels pinned to the ends of their range.
  task automatic pick_pixel(output logic [rgb2hsv_pkg::CHAN_W-1:0] r,
                            output logic [rgb2hsv_pkg::CHAN_W-1:0] g,
                            output logic [rgb2hsv_pkg::CHAN_W-1:0] b);
    int unsigned                    kind;
    logic [rgb2hsv_pkg::CHAN_W-1:0] base;
    kind = $urandom_range(0, 99);
    r    = rgb2hsv_pkg::CHAN_W'($urandom);
    g    = rgb2hsv_pkg::CHAN_W'($urandom);
    b    = rgb2hsv_pkg::CHAN_W'($urandom);
    if (kind < 15) begin
      base = rgb2hsv_pkg::CHAN_W'($urandom);
      r    = base;
      g    = base + rgb2hsv_pkg::CHAN_W'($urandom_range(0, 2));
      b    = base - rgb2hsv_pkg::CHAN_W'($urandom_range(0, 2));
    end else if (kind < 27) begin
      case ($urandom_range(0, 2))
        0:       g = r;
        1:       b = g;
        default: b = r;
      endcase
    end else if (kind < 40) begin
      r = extreme_chan();
      g = extreme_chan();
      b = extreme_chan();
    end
  endtask

  // Stimulus: reset, then directed and random pixels in bursts with gaps.
  initial begin
    logic [rgb2hsv_pkg::CHAN_W-1:0] r;
    logic [rgb2hsv_pkg::CHAN_W-1:0] g;
    logic [rgb2hsv_pkg::CHAN_W-1:0] b;
    int unsigned                    burst_left;
    int unsigned                    gap;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    burst_left = $urandom_range(1, 40);
    for (int i = 0; i < N_DIRECTED + N_RANDOM; i++) begin
      if (i < N_DIRECTED) {r, g, b} = DIRECTED_PIXELS[i];
      else                pick_pixel(r, g, b);
      send_pixel(r, g, b);
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        // A quarter of the bursts run straight on with no gap at all.
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end else begin
        burst_left--;
      end
    end
    in_valid_i <= 1'b0;
    // Drain the pipeline, then give stray beats a chance to show up.
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Sent %0d pixels, checked %0d HSV beats, %0d mismatches.",
             sb.pixels_in, sb.beats_checked, sb.mismatches);
    $display("Covered black %0d, grey %0d, red/green/blue max %0d/%0d/%0d, hue wraps %0d.",
             sb.n_black, sb.n_gray, sb.n_sector[rgb2hsv_pkg::SEC_RED],
             sb.n_sector[rgb2hsv_pkg::SEC_GREEN], sb.n_sector[rgb2hsv_pkg::SEC_BLUE],
             sb.n_wrap);
    if (sb.mismatches == 0) $display("simulation ok");
    else                    $display("simulation failed");
    $finish;
  end

  // Receiver: switch between stall patterns at random, including open stretches.
  rx_mode_e    rx_mode  = RX_OPEN;
  int unsigned rx_count = 0;
  int unsigned rx_hold  = 0;

  always @(posedge clk_i) begin
    rx_count <= rx_count + 1;
    if (rx_count % 150 == 0) rx_mode <= rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:     out_ready_i <= 1'b1;
      RX_PERIODIC: out_ready_i <= (rx_count % 4) != 3;
      RX_RANDOM:   out_ready_i <= 1'($urandom_range(0, 1));
      default: begin
        // Long stalls now and then, to back the pipeline up to the input.
        if (rx_hold != 0) begin
          out_ready_i <= 1'b0;
          rx_hold     <= rx_hold - 1;
        end else begin
          out_ready_i <= 1'b1;
          if ($urandom_range(0, 9) == 0) rx_hold <= $urandom_range(2, 12);
        end
      end
    endcase
  end

  // Check every result beat the core hands over.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_beat(hsv_t'{hue: hue_out_o, sat: saturation_out_o, value: value_out_o});
  end

  // Watchdog: stop a hung run.
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles.", IDLE_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
